>>> rtl/ps2mc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block.
// Depends on nothing; every other file of the block imports it.
package ps2mc_pkg;

    localparam int SIZE_W = 13;

    typedef struct packed {
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] screen_height;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_FLAGS = 2'd0,
        PH_DX    = 2'd1,
        PH_DY    = 2'd2
    } phase_t;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

    localparam int POS_X_RESET = 512;
    localparam int POS_Y_RESET = 384;

    localparam int STATUS_READY_BIT = 0;
    localparam int STATUS_AUX_BIT   = 5;
    localparam int FLAG_X_SIGN_BIT  = 4;
    localparam int FLAG_Y_SIGN_BIT  = 5;
    localparam int BUTTON_BITS      = 3;

endpackage

>>> rtl/ps2_mouse_packet_cursor.sv
// Top level of the PS/2 mouse packet decoder with cursor tracking.
// Depends on ps2mc_pkg, ps2mc_regs and ps2mc_axis.
//
// Channel   Direction  Handshake                 Content
// s_axis    in         tvalid/tready             one controller poll
// m_axis    out        tvalid/tready             cursor position and buttons
// apb       in         psel/penable/pready       screen width and height
//
// A poll is registered on acceptance and processed once the output is free, so a new
// poll can be taken every cycle while the output does not stall. A completed packet
// shows its result after its third byte passes the input register. A stalled result
// holds the processing register; the input stalls only when both stages are occupied.
// Reset clears the phase, valid flags and buttons and presets cursor and screen size.
module ps2_mouse_packet_cursor #(
    parameter int POS_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: ctrl_status [7:0], rx_byte [15:8]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cursor_x, cursor_y, button_bits, zero fill
    output logic [((2*POS_BITS+3+7)/8)*8-1:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ps2mc_pkg::*;

    localparam int TDATA_W = ((2*POS_BITS+3+7)/8)*8;
    localparam int PAD_W   = TDATA_W - (2*POS_BITS + 3);

    cfg_t cfg;

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg, in_byte_next;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             flag_reg, flag_next;
    logic [7:0]             dx_reg, dx_next;
    logic [POS_BITS-1:0]    pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0]    pos_y_reg, pos_y_next;
    logic [BUTTON_BITS-1:0] buttons_reg, buttons_next;
    logic                   m_valid_reg, m_valid_next;

    logic                   s_xfer;
    logic                   poll_good;
    logic                   advance;
    logic signed [9:0]      delta_x;
    logic signed [9:0]      delta_y;
    logic [POS_BITS-1:0]    clamp_x;
    logic [POS_BITS-1:0]    clamp_y;

    ps2mc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign delta_x = {flag_reg[FLAG_X_SIGN_BIT], flag_reg[FLAG_X_SIGN_BIT], dx_reg};
    assign delta_y = -$signed({flag_reg[FLAG_Y_SIGN_BIT], flag_reg[FLAG_Y_SIGN_BIT],
                               in_byte_reg});

    ps2mc_axis #(.POS_BITS(POS_BITS)) u_axis_x (
        .pos      (pos_x_reg),
        .delta    (delta_x),
        .size     (cfg.screen_width),
        .pos_next (clamp_x)
    );

    ps2mc_axis #(.POS_BITS(POS_BITS)) u_axis_y (
        .pos      (pos_y_reg),
        .delta    (delta_y),
        .size     (cfg.screen_height),
        .pos_next (clamp_y)
    );

    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign poll_good     = s_axis_tdata[STATUS_READY_BIT] && s_axis_tdata[STATUS_AUX_BIT];

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_xfer) begin
            in_valid_next = poll_good;
            in_byte_next  = s_axis_tdata[15:8];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        flag_next    = flag_reg;
        dx_next      = dx_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        buttons_next = buttons_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        if (advance) begin
            case (phase_reg)
                PH_FLAGS: begin
                    flag_next  = in_byte_reg;
                    phase_next = PH_DX;
                end
                PH_DX: begin
                    dx_next    = in_byte_reg;
                    phase_next = PH_DY;
                end
                default: begin
                    pos_x_next   = clamp_x;
                    pos_y_next   = clamp_y;
                    buttons_next = flag_reg[BUTTON_BITS-1:0];
                    m_valid_next = 1'b1;
                    phase_next   = PH_FLAGS;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        flag_reg    <= flag_next;
        dx_reg      <= dx_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_FLAGS;
            pos_x_reg    <= POS_BITS'(POS_X_RESET);
            pos_y_reg    <= POS_BITS'(POS_Y_RESET);
            buttons_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            buttons_reg  <= buttons_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, buttons_reg, pos_y_reg, pos_x_reg};

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> phase_reg == PH_FLAGS && !m_axis_tvalid && !in_valid_reg)
        else $error("block not idle after reset");

    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_reg))
        else $error("packet phase moved without a processed byte");

    a_pos_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(pos_x_reg) || !$stable(pos_y_reg) |-> m_axis_tvalid)
        else $error("cursor moved without a result");

    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(phase_reg) != PH_FLAGS && $past(phase_reg) != PH_DX)
        else $error("result raised outside the third byte");

endmodule

>>> rtl/ps2mc_regs.sv
// APB-style register file holding the screen size.
// Depends on ps2mc_pkg for the register indexes and the configuration struct.
module ps2mc_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ps2mc_pkg::cfg_t      cfg
);
    import ps2mc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = pwdata[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = pwdata[SIZE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.screen_height};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/ps2mc_axis.sv
// One cursor axis: adds a signed step to the position and clamps to the screen.
// Depends on ps2mc_pkg for the screen size width.
module ps2mc_axis #(
    parameter int POS_BITS = 12
) (
    input  logic [POS_BITS-1:0]         pos,
    input  logic signed [9:0]           delta,
    input  logic [ps2mc_pkg::SIZE_W-1:0] size,
    output logic [POS_BITS-1:0]         pos_next
);
    import ps2mc_pkg::*;

    localparam int SW = POS_BITS + 2;
    localparam int LW = ((POS_BITS > SIZE_W) ? POS_BITS : SIZE_W) + 1;
    localparam logic [LW-1:0] POS_LIMIT = LW'(1) << POS_BITS;

    logic signed [SW-1:0] sum;
    logic [LW-1:0]        size_ext;
    logic [LW-1:0]        lim;
    logic [LW-1:0]        max_val;
    logic [POS_BITS-1:0]  max_pos;

    assign sum      = $signed({2'b00, pos}) + SW'(delta);
    assign size_ext = LW'(size);

    always_comb begin
        if (size_ext == '0) begin
            lim = LW'(1);
        end else if (size_ext > POS_LIMIT) begin
            lim = POS_LIMIT;
        end else begin
            lim = size_ext;
        end
    end

    assign max_val = lim - LW'(1);
    assign max_pos = max_val[POS_BITS-1:0];

    always_comb begin
        if (sum < 0) begin
            pos_next = '0;
        end else if (sum > $signed({2'b00, max_pos})) begin
            pos_next = max_pos;
        end else begin
            pos_next = sum[POS_BITS-1:0];
        end
    end

endmodule
